// ----- hw/rtl/bpc_pkg.sv -----
// Shared types and constants for the barometric pressure compensation pipeline
`default_nettype none
package bpc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_AC1_AC2  = 3'd0,
        CFG_AC3_AC4  = 3'd1,
        CFG_AC5_AC6  = 3'd2,
        CFG_B1_B2    = 3'd3,
        CFG_MC_MD    = 3'd4,
        CFG_OSS      = 3'd5
    } cfg_idx_t;

    localparam logic [31:0] RST_AC1_AC2 = 32'd26804152;
    localparam logic [31:0] RST_AC3_AC4 = 32'd3352395749;
    localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
    localparam logic [31:0] RST_B1_B2   = 32'd405667844;
    localparam logic [31:0] RST_MC_MD   = 32'd3724086068;

    localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
    localparam logic [31:0]        B4_BIAS    = 32'd32768;
    localparam logic [15:0]        B7_SCALE   = 16'd50000;
    localparam logic signed [31:0] P_SQ_COEF  = 32'sd3038;
    localparam logic signed [31:0] P_LIN_COEF = -32'sd7357;
    localparam logic signed [31:0] P_OFFSET   = 32'sd3791;

    // sideband through the temperature divider
    typedef struct packed {
        logic signed [31:0] x1;
        logic [23:0]        up;
        logic               err;
        logic               neg;
    } div_t_side_t;

    // sideband through the pressure divider
    typedef struct packed {
        logic signed [15:0] temp;
        logic               err;
        logic               dbl;
    } div_p_side_t;

endpackage
`default_nettype wire

// ----- hw/rtl/baro_pressure_compensation.sv -----
// Top level: pipelined integer temperature and pressure compensation
//
//  channel | direction | beat contents
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | raw_temperature, raw_pressure_bytes
//  m_      | out       | temperature_tenths, pressure_pa, divide_error
//  cfg_    | in        | cfg_index, cfg_data (calibration and oversampling)
//
// One beat enters per cycle while s_ready is high. A beat passes through 75
// register stages, the two 32-stage dividers plus eleven arithmetic and output
// stages, the first loaded at the accepting edge.
// The whole pipeline advances together: a stalled output holds every stage
// and drops s_ready, so nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and reloads calibration.
// Configuration writes are taken every cycle; write only while idle.
`default_nettype none
module baro_pressure_compensation (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [15:0]         s_raw_temperature,
    input  wire logic [23:0]         s_raw_pressure_bytes,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [15:0]       m_temperature_tenths,
    output logic signed [31:0]       m_pressure_pa,
    output logic                     m_divide_error,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire bpc_pkg::cfg_idx_t   cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import bpc_pkg::*;

    // ---------------- configuration ----------------
    logic [31:0] cal0_reg, cal1_reg, cal2_reg, cal3_reg, cal4_reg;
    logic [1:0]  oss_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal0_reg <= RST_AC1_AC2;
            cal1_reg <= RST_AC3_AC4;
            cal2_reg <= RST_AC5_AC6;
            cal3_reg <= RST_B1_B2;
            cal4_reg <= RST_MC_MD;
            oss_reg  <= 2'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_AC1_AC2: cal0_reg <= cfg_data;
                CFG_AC3_AC4: cal1_reg <= cfg_data;
                CFG_AC5_AC6: cal2_reg <= cfg_data;
                CFG_B1_B2:   cal3_reg <= cfg_data;
                CFG_MC_MD:   cal4_reg <= cfg_data;
                CFG_OSS:     oss_reg  <= cfg_data[1:0];
                default: ;   // unknown index: ignore
            endcase
        end
    end

    // coefficients: signed ones sign-extended, AC4..AC6 unsigned
    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;
    assign ac1 = {{16{cal0_reg[31]}}, cal0_reg[31:16]};
    assign ac2 = {{16{cal0_reg[15]}}, cal0_reg[15:0]};
    assign ac3 = {{16{cal1_reg[31]}}, cal1_reg[31:16]};
    assign ac4 = cal1_reg[15:0];
    assign ac5 = cal2_reg[31:16];
    assign ac6 = cal2_reg[15:0];
    assign b1  = {{16{cal3_reg[31]}}, cal3_reg[31:16]};
    assign b2  = {{16{cal3_reg[15]}}, cal3_reg[15:0]};
    assign mc  = {{16{cal4_reg[31]}}, cal4_reg[31:16]};
    assign md  = {{16{cal4_reg[15]}}, cal4_reg[15:0]};

    // global advance: every stage moves when the output slot frees
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- stage A1: (UT - AC6) * AC5 ----------------
    logic               a1_vld_reg;
    logic signed [31:0] a1_prod_reg;
    logic [23:0]        a1_up_reg;
    logic signed [16:0] a1_diff;
    logic signed [33:0] a1_prod;

    assign a1_diff = $signed({1'b0, s_raw_temperature}) - $signed({1'b0, ac6});
    assign a1_prod = a1_diff * $signed({1'b0, ac5});

    // ---------------- stage A2: divider operands ----------------
    logic               a2_vld_reg;
    logic [31:0]        a2_dvd_reg, a2_dvs_reg;
    div_t_side_t        a2_side_reg;
    logic signed [31:0] a2_x1, a2_den, a2_num;

    assign a2_x1  = a1_prod_reg >>> 15;
    assign a2_den = a2_x1 + md;
    assign a2_num = mc <<< 11;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
        end else if (adv) begin
            a1_vld_reg <= s_valid;
            a2_vld_reg <= a1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_prod_reg     <= a1_prod[31:0];
            a1_up_reg       <= s_raw_pressure_bytes >> (4'd8 - {2'b00, oss_reg});
            a2_dvd_reg      <= a2_num[31] ? 32'(-a2_num) : a2_num;
            a2_dvs_reg      <= a2_den[31] ? 32'(-a2_den) : a2_den;
            a2_side_reg.x1  <= a2_x1;
            a2_side_reg.up  <= a1_up_reg;
            a2_side_reg.err <= (a2_den == 32'sd0);
            a2_side_reg.neg <= a2_num[31] ^ a2_den[31];
        end
    end

    // ---------------- temperature divider ----------------
    logic        dt_vld;
    logic [31:0] dt_q;
    div_t_side_t dt_side;

    bpc_udiv #(.W(32), .SW($bits(div_t_side_t))) u_div_t (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .in_valid     (a2_vld_reg),
        .in_dividend  (a2_dvd_reg),
        .in_divisor   (a2_dvs_reg),
        .in_side      (a2_side_reg),
        .out_valid    (dt_vld),
        .out_quotient (dt_q),
        .out_side     (dt_side)
    );

    // ---------------- stage D1: B5, temperature, B6 ----------------
    logic signed [31:0] d1_x2, d1_b5, d1_t32;
    logic signed [15:0] d1_temp;

    assign d1_x2  = dt_side.err ? 32'sd0 : (dt_side.neg ? 32'(-$signed(dt_q)) : $signed(dt_q));
    assign d1_b5  = dt_side.x1 + d1_x2;
    assign d1_t32 = (d1_b5 + 32'sd8) >>> 4;

    always_comb begin
        if (d1_t32 > 32'sd32767) begin
            d1_temp = 16'sh7fff;
        end else if (d1_t32 < -32'sd32768) begin
            d1_temp = -16'sh8000;
        end else begin
            d1_temp = d1_t32[15:0];
        end
    end

    logic               d1_vld_reg;
    logic signed [31:0] d1_b6_reg;
    logic signed [15:0] d1_temp_reg;
    logic               d1_err_reg;
    logic [23:0]        d1_up_reg;

    // ---------------- stage B1: B6 products ----------------
    logic               b1_vld_reg;
    logic signed [31:0] b1_sq_reg, b1_pac2_reg, b1_pac3_reg;
    logic signed [15:0] b1_temp_reg;
    logic               b1_err_reg;
    logic [23:0]        b1_up_reg;

    // ---------------- stage B2: second products ----------------
    logic               b2_vld_reg;
    logic signed [31:0] b2_pb2_reg, b2_pb1_reg, b2_x2a_reg, b2_x1c_reg;
    logic signed [15:0] b2_temp_reg;
    logic               b2_err_reg;
    logic [23:0]        b2_up_reg;
    logic signed [31:0] b2_sq12;

    assign b2_sq12 = b1_sq_reg >>> 12;

    // ---------------- stage B3: B3 and X3 ----------------
    logic               b3_vld_reg;
    logic signed [31:0] b3_b3_reg, b3_x3_reg;
    logic signed [15:0] b3_temp_reg;
    logic               b3_err_reg;
    logic [23:0]        b3_up_reg;
    logic signed [31:0] b3_x3a, b3_v, b3_x3b;

    assign b3_x3a = (b2_pb2_reg >>> 11) + b2_x2a_reg;
    assign b3_v   = ((ac1 <<< 2) + b3_x3a <<< oss_reg) + 32'sd2;
    assign b3_x3b = (b2_x1c_reg + (b2_pb1_reg >>> 16) + 32'sd2) >>> 2;

    // ---------------- stage B4: B4 and B7 ----------------
    logic               b4_vld_reg;
    logic [31:0]        b4_b4_reg, b4_b7_reg;
    logic signed [15:0] b4_temp_reg;
    logic               b4_err_reg;
    logic [31:0]        b4_prod, b4_b7;

    assign b4_prod = ({16'd0, ac4} * (b3_x3_reg + B4_BIAS));
    assign b4_b7   = (32'(b3_up_reg) - b3_b3_reg) * {16'd0, B7_SCALE >> oss_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_vld_reg <= 1'b0;
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            b4_vld_reg <= 1'b0;
        end else if (adv) begin
            d1_vld_reg <= dt_vld;
            b1_vld_reg <= d1_vld_reg;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
            b4_vld_reg <= b3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_b6_reg   <= d1_b5 - B6_OFFSET;
            d1_temp_reg <= d1_temp;
            d1_err_reg  <= dt_side.err;
            d1_up_reg   <= dt_side.up;

            b1_sq_reg   <= d1_b6_reg * d1_b6_reg;
            b1_pac2_reg <= ac2 * d1_b6_reg;
            b1_pac3_reg <= ac3 * d1_b6_reg;
            b1_temp_reg <= d1_temp_reg;
            b1_err_reg  <= d1_err_reg;
            b1_up_reg   <= d1_up_reg;

            b2_pb2_reg  <= b2 * b2_sq12;
            b2_pb1_reg  <= b1 * b2_sq12;
            b2_x2a_reg  <= b1_pac2_reg >>> 11;
            b2_x1c_reg  <= b1_pac3_reg >>> 13;
            b2_temp_reg <= b1_temp_reg;
            b2_err_reg  <= b1_err_reg;
            b2_up_reg   <= b1_up_reg;

            // signed divide by 4, truncating toward zero
            b3_b3_reg   <= (b3_v + (b3_v[31] ? 32'sd3 : 32'sd0)) >>> 2;
            b3_x3_reg   <= b3_x3b;
            b3_temp_reg <= b2_temp_reg;
            b3_err_reg  <= b2_err_reg;
            b3_up_reg   <= b2_up_reg;

            b4_b4_reg   <= b4_prod >> 15;
            b4_b7_reg   <= b4_b7;
            b4_temp_reg <= b3_temp_reg;
            b4_err_reg  <= b3_err_reg;
        end
    end

    // ---------------- pressure divider ----------------
    div_p_side_t dp_in_side, dp_side;
    logic        dp_vld;
    logic [31:0] dp_q;

    // keep both orderings: double before dividing unless B7 has its top bit set
    assign dp_in_side.temp = b4_temp_reg;
    assign dp_in_side.err  = b4_err_reg || (b4_b4_reg == 32'd0);
    assign dp_in_side.dbl  = b4_b7_reg[31];

    bpc_udiv #(.W(32), .SW($bits(div_p_side_t))) u_div_p (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .in_valid     (b4_vld_reg),
        .in_dividend  (b4_b7_reg[31] ? b4_b7_reg : {b4_b7_reg[30:0], 1'b0}),
        .in_divisor   (b4_b4_reg),
        .in_side      (dp_in_side),
        .out_valid    (dp_vld),
        .out_quotient (dp_q),
        .out_side     (dp_side)
    );

    // ---------------- stages C0..C2: final correction ----------------
    logic               c0_vld_reg, c1_vld_reg, c2_vld_reg;
    logic signed [31:0] c0_p_reg, c1_p_reg, c2_p_reg;
    logic signed [31:0] c1_x1m_reg, c1_x2m_reg, c2_x1s_reg, c2_x2s_reg;
    logic signed [31:0] c2_sq;
    logic signed [15:0] c0_temp_reg, c1_temp_reg, c2_temp_reg;
    logic               c0_err_reg, c1_err_reg, c2_err_reg;
    logic signed [31:0] c1_pp;

    assign c1_pp = c0_p_reg >>> 8;
    assign c2_sq = c1_x1m_reg * P_SQ_COEF;

    // output register
    logic               m_valid_reg;
    logic signed [15:0] m_temp_reg;
    logic signed [31:0] m_p_reg;
    logic               m_err_reg;
    logic signed [31:0] out_p;

    assign out_p = c2_p_reg + ((c2_x1s_reg + c2_x2s_reg + P_OFFSET) >>> 4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_vld_reg  <= 1'b0;
            c1_vld_reg  <= 1'b0;
            c2_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            c0_vld_reg  <= dp_vld;
            c1_vld_reg  <= c0_vld_reg;
            c2_vld_reg  <= c1_vld_reg;
            m_valid_reg <= c2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c0_p_reg    <= dp_side.dbl ? {dp_q[30:0], 1'b0} : dp_q;
            c0_temp_reg <= dp_side.temp;
            c0_err_reg  <= dp_side.err;

            c1_x1m_reg  <= c1_pp * c1_pp;
            c1_x2m_reg  <= P_LIN_COEF * c0_p_reg;
            c1_p_reg    <= c0_p_reg;
            c1_temp_reg <= c0_temp_reg;
            c1_err_reg  <= c0_err_reg;

            c2_x1s_reg  <= c2_sq >>> 16;
            c2_x2s_reg  <= c1_x2m_reg >>> 16;
            c2_p_reg    <= c1_p_reg;
            c2_temp_reg <= c1_temp_reg;
            c2_err_reg  <= c1_err_reg;

            m_temp_reg  <= c2_temp_reg;
            m_p_reg     <= c2_err_reg ? 32'sd0 : out_p;
            m_err_reg   <= c2_err_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_temperature_tenths = m_temp_reg;
    assign m_pressure_pa        = m_p_reg;
    assign m_divide_error       = m_err_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/bpc_udiv.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage
`default_nettype none
module bpc_udiv #(
    parameter int W  = 32,
    parameter int SW = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [W-1:0]  in_dividend,
    input  wire logic [W-1:0]  in_divisor,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [W-1:0]       out_quotient,
    output logic [SW-1:0]      out_side
);
    logic [W-1:0]  rem_reg  [0:W-1];
    logic [W-1:0]  dq_reg   [0:W-1];
    logic [W-1:0]  dvs_reg  [0:W-1];
    logic [SW-1:0] side_reg [0:W-1];
    logic          vld_reg  [0:W-1];

    logic [W-1:0]  rem_src  [0:W-1];
    logic [W-1:0]  dq_src   [0:W-1];
    logic [W-1:0]  dvs_src  [0:W-1];
    logic [SW-1:0] side_src [0:W-1];
    logic          vld_src  [0:W-1];

    assign rem_src[0]  = '0;
    assign dq_src[0]   = in_dividend;
    assign dvs_src[0]  = in_divisor;
    assign side_src[0] = in_side;
    assign vld_src[0]  = in_valid;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W:0]   part;
        logic [W:0]   diff;
        logic         ge;

        if (k > 0) begin : g_src
            assign rem_src[k]  = rem_reg[k-1];
            assign dq_src[k]   = dq_reg[k-1];
            assign dvs_src[k]  = dvs_reg[k-1];
            assign side_src[k] = side_reg[k-1];
            assign vld_src[k]  = vld_reg[k-1];
        end

        // shift in the next dividend bit, subtract if it fits
        assign part = {rem_src[k], dq_src[k][W-1]};
        assign diff = part - {1'b0, dvs_src[k]};
        assign ge   = ~diff[W];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_src[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? diff[W-1:0] : part[W-1:0];
                dq_reg[k]   <= {dq_src[k][W-2:0], ge};
                dvs_reg[k]  <= dvs_src[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid    = vld_reg[W-1];
    assign out_quotient = dq_reg[W-1];
    assign out_side     = side_reg[W-1];
endmodule
`default_nettype wire

// ----- hw/rtl/bpc_checker.sv -----
// Port-level assertions for the compensation block, bound to the top level
`default_nettype none
module bpc_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_temperature_tenths,
    input wire logic signed [31:0] m_pressure_pa,
    input wire logic               m_divide_error
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressure_pa)
            && $stable(m_temperature_tenths) && $stable(m_divide_error))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_error |-> m_pressure_pa == 32'sd0)
        else $error("divide error with nonzero pressure");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during output stall");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
endmodule

bind baro_pressure_compensation bpc_checker u_bpc_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_temperature_tenths (m_temperature_tenths),
    .m_pressure_pa        (m_pressure_pa),
    .m_divide_error       (m_divide_error)
);
`default_nettype wire
